FILE: rtl/core/hmip_pkg.sv
// Package for the hex memory image parser.
// Holds widths, character codes, parser mode, result codes and shared structs.
// No dependencies.
package hmip_pkg;

   localparam int DigitsPerWord = 8;
   localparam int CountW        = $clog2(DigitsPerWord + 1);
   localparam int CharW         = 8;
   localparam int NibbleW       = 4;
   localparam int AddrW         = 32;
   localparam int DataW         = 32;
   localparam int LineW         = 24;
   localparam int CodeW         = 2;

   localparam logic [AddrW-1:0] OffsetStep = AddrW'(4);
   localparam logic [LineW-1:0] LineMax    = {LineW{1'b1}};

   localparam logic [CharW-1:0] CharAt      = 8'h40;
   localparam logic [CharW-1:0] CharNewline = 8'h0A;
   localparam logic [CharW-1:0] CharTab     = 8'h09;
   localparam logic [CharW-1:0] CharVtab    = 8'h0B;
   localparam logic [CharW-1:0] CharFeed    = 8'h0C;
   localparam logic [CharW-1:0] CharReturn  = 8'h0D;
   localparam logic [CharW-1:0] CharSpace   = 8'h20;
   localparam logic [CharW-1:0] CharZero    = 8'h30;
   localparam logic [CharW-1:0] CharNine    = 8'h39;
   localparam logic [CharW-1:0] CharUpperA  = 8'h41;
   localparam logic [CharW-1:0] CharUpperF  = 8'h46;
   localparam logic [CharW-1:0] CharLowerA  = 8'h61;
   localparam logic [CharW-1:0] CharLowerF  = 8'h66;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DATA,
      MODE_ADDR,
      MODE_HALTED
   } parse_mode_type;

   typedef enum logic [CodeW-1:0] {
      STATUS_WRITE = 2'd0,
      STATUS_DONE  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [CodeW-1:0] {
      ERR_INVALID_CHAR = 2'd0,
      ERR_BAD_DIGIT    = 2'd1,
      ERR_END_IN_WORD  = 2'd2
   } error_code_type;

   typedef struct packed {
      logic               is_hex;
      logic [NibbleW-1:0] hex_value;
      logic               is_at;
      logic               is_newline;
      logic               is_blank;
   } char_class_type;

   typedef struct packed {
      status_type       status;
      logic [AddrW-1:0] write_address;
      logic [DataW-1:0] write_data;
      error_code_type   error_code;
      logic [LineW-1:0] line_number;
   } rsp_item_type;

endpackage

FILE: rtl/core/hmip_if.sv
// Channel interfaces of the hex memory image parser: character requests and results.
// Depends on hmip_pkg for field widths.
interface hmip_req_if import hmip_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CharW-1:0] char_byte;
   logic             end_of_input;

   modport source (output valid, output char_byte, output end_of_input, input ready);
   modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface hmip_rsp_if import hmip_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CodeW-1:0] status;
   logic [AddrW-1:0] write_address;
   logic [DataW-1:0] write_data;
   logic [CodeW-1:0] error_code;
   logic [LineW-1:0] line_number;

   modport source (output valid, output status, output write_address, output write_data,
                   output error_code, output line_number, input ready);
   modport sink   (input valid, input status, input write_address, input write_data,
                   input error_code, input line_number, output ready);
endinterface

FILE: rtl/core/hmip_char_decode.sv
// Character classifier: hex digit value, '@', newline and whitespace detection.
// Depends on hmip_pkg.
module hmip_char_decode import hmip_pkg::*; (
   input  logic [CharW-1:0] char_byte,
   output char_class_type   char_class
);

   logic is_digit;
   logic is_letter;

   assign is_digit  = (char_byte >= CharZero) && (char_byte <= CharNine);
   assign is_letter = ((char_byte >= CharLowerA) && (char_byte <= CharLowerF)) ||
                      ((char_byte >= CharUpperA) && (char_byte <= CharUpperF));

   always_comb begin
      char_class.is_hex     = is_digit || is_letter;
      // Letters a-f and A-F both have low nibble 1..6, so adding nine gives 10..15.
      char_class.hex_value  = is_digit ? char_byte[NibbleW-1:0]
                                       : char_byte[NibbleW-1:0] + NibbleW'(9);
      char_class.is_at      = (char_byte == CharAt);
      char_class.is_newline = (char_byte == CharNewline);
      char_class.is_blank   = (char_byte == CharSpace) || (char_byte == CharTab) ||
                              (char_byte == CharNewline) || (char_byte == CharVtab) ||
                              (char_byte == CharFeed) || (char_byte == CharReturn);
   end

endmodule

FILE: rtl/core/hmip_parse_core.sv
// Parser core: input register, parser state and the per-character step.
// Depends on hmip_pkg and hmip_char_decode.
module hmip_parse_core import hmip_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [AddrW-1:0] base_address,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CharW-1:0] req_char_byte,
   input  logic             req_end_of_input,
   input  logic             out_free,
   output logic             result_load,
   output rsp_item_type     result_item
);

   logic                  in_valid_ff;
   logic [CharW-1:0]      char_ff;
   logic                  eoi_ff;
   parse_mode_type        mode_ff, mode_in;
   logic [CountW-1:0]     count_ff, count_in;
   logic [DataW-1:0]      acc_ff, acc_in;
   logic [AddrW-1:0]      offset_ff, offset_in;
   logic [LineW-1:0]      line_ff, line_in;

   char_class_type        cls;
   logic                  advance;
   logic                  in_token;
   logic [CountW-1:0]     count_base;
   logic [CountW-1:0]     count_inc;
   logic [DataW-1:0]      acc_base;
   logic [DataW-1:0]      acc_next;
   logic                  word_done;

   hmip_char_decode u_decode (
      .char_byte  (char_ff),
      .char_class (cls)
   );

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         char_ff <= req_char_byte;
         eoi_ff  <= req_end_of_input;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         acc_ff    <= '0;
         offset_ff <= '0;
         line_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         acc_ff    <= acc_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
      end
   end

   // A hex digit seen between tokens starts a new word from an empty accumulator.
   assign in_token   = (mode_ff == MODE_DATA) || (mode_ff == MODE_ADDR);
   assign count_base = in_token ? count_ff : '0;
   assign acc_base   = in_token ? acc_ff : '0;
   assign count_inc  = count_base + CountW'(1);
   assign acc_next   = (acc_base << NibbleW) | DataW'(cls.hex_value);
   assign word_done  = (count_inc == CountW'(DigitsPerWord));

   always_comb begin
      mode_in = mode_ff;
      if (advance) begin
         case (mode_ff)
            MODE_IDLE: begin
               if (eoi_ff) begin
                  mode_in = MODE_HALTED;
               end else if (cls.is_at) begin
                  mode_in = MODE_ADDR;
               end else if (cls.is_hex) begin
                  mode_in = word_done ? MODE_IDLE : MODE_DATA;
               end else if (!cls.is_blank) begin
                  mode_in = MODE_HALTED;
               end
            end
            MODE_DATA, MODE_ADDR: begin
               if (eoi_ff || !cls.is_hex) begin
                  mode_in = MODE_HALTED;
               end else if (word_done) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_HALTED: begin
               mode_in = MODE_HALTED;
            end
            default: begin
               mode_in = MODE_HALTED;
            end
         endcase
      end
   end

   always_comb begin
      result_load               = 1'b0;
      result_item.status        = STATUS_WRITE;
      result_item.write_address = '0;
      result_item.write_data    = '0;
      result_item.error_code    = ERR_INVALID_CHAR;
      result_item.line_number   = line_ff;
      count_in                  = count_ff;
      acc_in                    = acc_ff;
      offset_in                 = offset_ff;
      line_in                   = line_ff;

      if (advance && (mode_ff != MODE_HALTED)) begin
         if (eoi_ff) begin
            result_load = 1'b1;
            if (mode_ff == MODE_IDLE) begin
               result_item.status = STATUS_DONE;
            end else begin
               result_item.status     = STATUS_ERROR;
               result_item.error_code = ERR_END_IN_WORD;
            end
         end else if ((mode_ff == MODE_IDLE) && cls.is_at) begin
            count_in = '0;
            acc_in   = '0;
         end else if ((mode_ff == MODE_IDLE) && cls.is_newline) begin
            if (line_ff != LineMax) begin
               line_in = line_ff + LineW'(1);
            end
         end else if (cls.is_hex) begin
            acc_in = acc_next;
            if (word_done) begin
               count_in = '0;
               if (mode_ff == MODE_ADDR) begin
                  offset_in = acc_next;
               end else begin
                  result_load               = 1'b1;
                  result_item.write_address = base_address + offset_ff;
                  result_item.write_data    = acc_next;
                  offset_in                 = offset_ff + OffsetStep;
               end
            end else begin
               count_in = count_inc;
            end
         end else if ((mode_ff == MODE_IDLE) && cls.is_blank) begin
            count_in = count_ff;
         end else begin
            result_load            = 1'b1;
            result_item.status     = STATUS_ERROR;
            result_item.error_code = (mode_ff == MODE_IDLE) ? ERR_INVALID_CHAR
                                                            : ERR_BAD_DIGIT;
         end
      end
   end

endmodule

FILE: rtl/core/hmip_rsp_reg.sv
// Result register: holds one finished item until the sink takes it.
// Depends on hmip_pkg.
module hmip_rsp_reg import hmip_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   output logic         out_free
);

   logic         valid_ff;
   rsp_item_type item_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

FILE: rtl/core/hex_memory_image_parser.sv
// Channel   | Direction | Contents
// req       | in        | char_byte, end_of_input (valid/ready)
// rsp       | out       | status, write_address, write_data, error_code, line_number
// csr       | in        | write enable and 32-bit base address
//
// One character item per cycle is sustained while the result register is not stalled. Each
// item is decoded in the input register and applied to the parser state, and its result
// (if any) is registered in the result register. Reset is synchronous and returns the
// parser to the idle state with a zero offset, line count and base address. A stalled
// result register holds the input register; while it drains, a new item is still taken.
// Top level of the hex memory image parser; depends on hmip_pkg, hmip_if and the submodules.
module hex_memory_image_parser import hmip_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [AddrW-1:0] csr_write_data,
   hmip_req_if.sink         req_channel,
   hmip_rsp_if.source       rsp_channel
);

   logic [AddrW-1:0] base_address_ff;
   logic             out_free;
   logic             result_load;
   rsp_item_type     result_item;
   rsp_item_type     rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= '0;
      end else if (csr_write_enable) begin
         base_address_ff <= csr_write_data;
      end
   end

   hmip_parse_core u_core (
      .clock            (clock),
      .reset            (reset),
      .base_address     (base_address_ff),
      .req_valid        (req_channel.valid),
      .req_ready        (req_channel.ready),
      .req_char_byte    (req_channel.char_byte),
      .req_end_of_input (req_channel.end_of_input),
      .out_free         (out_free),
      .result_load      (result_load),
      .result_item      (result_item)
   );

   hmip_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_load),
      .load_item (result_item),
      .rsp_ready (rsp_channel.ready),
      .rsp_valid (rsp_channel.valid),
      .rsp_item  (rsp_item),
      .out_free  (out_free)
   );

   assign rsp_channel.status        = rsp_item.status;
   assign rsp_channel.write_address = rsp_item.write_address;
   assign rsp_channel.write_data    = rsp_item.write_data;
   assign rsp_channel.error_code    = rsp_item.error_code;
   assign rsp_channel.line_number   = rsp_item.line_number;

endmodule

FILE: rtl/core/hmip_checker.sv
// Port-level checks for the hex memory image parser, bound to the top level.
// Depends on hmip_pkg.
module hmip_checker import hmip_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [CodeW-1:0] rsp_status,
   input logic [AddrW-1:0] rsp_write_address,
   input logic [DataW-1:0] rsp_write_data,
   input logic [CodeW-1:0] rsp_error_code
);

   // A waiting result is never dropped.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Once a done or error item is taken, the parser is halted and shows nothing more.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready &&
      ((rsp_status == STATUS_DONE) || (rsp_status == STATUS_ERROR)) |=> !rsp_valid)
      else $error("result item after done or error");

   // Only a word write carries an address and data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_WRITE) |->
      (rsp_write_address == '0) && (rsp_write_data == '0))
      else $error("address or data on a non-write result");

   // Only an error carries a nonzero error code, and no unused status appears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_ERROR) || (rsp_error_code == ERR_INVALID_CHAR)) &&
      ((rsp_status == STATUS_WRITE) || (rsp_status == STATUS_DONE) ||
       (rsp_status == STATUS_ERROR)))
      else $error("inconsistent status and error code");

endmodule

bind hex_memory_image_parser hmip_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_channel.valid),
   .rsp_ready         (rsp_channel.ready),
   .rsp_status        (rsp_channel.status),
   .rsp_write_address (rsp_channel.write_address),
   .rsp_write_data    (rsp_channel.write_data),
   .rsp_error_code    (rsp_channel.error_code)
);
